@@ sv/spd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the shortest path unit: transaction
// formats, register indexes, operation codes and parameter defaults.
// ----------------------------------------------------------------------------
package spd_pkg;

    // parameter defaults
    localparam int MAX_VERTICES_DEF = 32;
    localparam int WEIGHT_BITS_DEF  = 16;

    // field widths of the transactions
    localparam int VERTEX_W   = 5;
    localparam int COST_W     = 16;
    localparam int DISTANCE_W = 21;

    // configuration port
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 6;
    localparam int VERTEX_COUNT_W  = 6;
    localparam int SOURCE_VERTEX_W = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_VERTEX = 2'd1;

    localparam logic [VERTEX_COUNT_W-1:0]  VERTEX_COUNT_RESET  = 6'd32;
    localparam logic [SOURCE_VERTEX_W-1:0] SOURCE_VERTEX_RESET = 5'd0;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // input transaction
    typedef struct packed {
        logic                op;
        logic [VERTEX_W-1:0] row;
        logic [VERTEX_W-1:0] col;
        logic                edge_present;
        logic [COST_W-1:0]   cost;
    } in_item_t;

    // output transaction
    typedef struct packed {
        logic [VERTEX_W-1:0]   vertex;
        logic [DISTANCE_W-1:0] distance;
        logic [VERTEX_W-1:0]   predecessor;
        logic                  reachable;
        logic                  last;
    } out_item_t;

endpackage

@@ sv/spd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/spd_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_engine
// Search sequencer: minimum scan over the distance memory, relaxation of
// one matrix row per round, then one result transaction per vertex.
// ----------------------------------------------------------------------------
module spd_engine #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // run command
    input  logic                                     run_start,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]        run_count,
    input  logic [$clog2(MAX_VERTICES)-1:0]          run_source,
    input  logic                                     run_source_ok,
    output logic                                     idle,
    // weight matrix read port
    output logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0] w_rd_addr,
    input  logic [WEIGHT_BITS:0]                     w_rd_data,
    // distance memory
    output logic                                     d_we,
    output logic [$clog2(MAX_VERTICES)-1:0]          d_wr_addr,
    output logic [$clog2(MAX_VERTICES)+WEIGHT_BITS+$clog2(MAX_VERTICES)-1:0] d_wr_data,
    output logic [$clog2(MAX_VERTICES)-1:0]          d_rd_addr,
    input  logic [$clog2(MAX_VERTICES)+WEIGHT_BITS+$clog2(MAX_VERTICES)-1:0] d_rd_data,
    // result channel
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output spd_pkg::out_item_t                       out_data
);

    import spd_pkg::*;

    localparam int VIDX_W  = $clog2(MAX_VERTICES);
    localparam int NCNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int WADDR_W = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int DIST_W  = WEIGHT_BITS + VIDX_W;
    localparam int DENT_W  = VIDX_W + DIST_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RELAX,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t                  state_reg, state_next;
    logic [NCNT_W-1:0]       n_reg, n_next;
    logic [NCNT_W-1:0]       cnt_reg, cnt_next;
    logic                    pipe_vld_reg, pipe_vld_next;
    logic [VIDX_W-1:0]       pipe_idx_reg, pipe_idx_next;
    logic                    found_reg, found_next;
    logic [DIST_W-1:0]       best_reg, best_next;
    logic [VIDX_W-1:0]       u_reg, u_next;
    logic [WADDR_W-1:0]      base_reg, base_next;
    logic [MAX_VERTICES-1:0] reached_reg, reached_next;
    logic [MAX_VERTICES-1:0] settled_reg, settled_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg, out_data_next;

    logic [NCNT_W-1:0]       last_idx;
    logic [NCNT_W-1:0]       cnt_inc;
    logic [DIST_W-1:0]       rd_dist;
    logic [VIDX_W-1:0]       rd_pred;
    logic                    w_flag;
    logic [DIST_W-1:0]       cand;
    logic                    pipe_last;
    logic                    take;
    logic                    emit_load;

    assign last_idx  = n_reg - NCNT_W'(1);
    assign cnt_inc   = cnt_reg + NCNT_W'(1);
    assign rd_dist   = d_rd_data[DIST_W-1:0];
    assign rd_pred   = d_rd_data[DENT_W-1:DIST_W];
    assign w_flag    = w_rd_data[WEIGHT_BITS];
    assign cand      = best_reg + DIST_W'(w_rd_data[WEIGHT_BITS-1:0]);
    assign pipe_last = pipe_vld_reg && (pipe_idx_reg == last_idx[VIDX_W-1:0]);
    assign emit_load = !out_valid_reg || !out_stall;

    // sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        pipe_vld_next  = 1'b0;
        pipe_idx_next  = pipe_idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        u_next         = u_reg;
        base_next      = base_reg;
        reached_next   = reached_reg;
        settled_next   = settled_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        take           = 1'b0;

        d_we      = 1'b0;
        d_wr_addr = pipe_idx_reg;
        d_wr_data = {u_reg, cand};
        d_rd_addr = cnt_reg[VIDX_W-1:0];
        w_rd_addr = base_reg + WADDR_W'(cnt_reg[VIDX_W-1:0]);

        unique case (state_reg)
            S_IDLE:
            begin
                if (run_start)
                begin
                    n_next       = run_count;
                    cnt_next     = '0;
                    found_next   = 1'b0;
                    reached_next = '0;
                    settled_next = '0;
                    if (run_source_ok)
                    begin
                        // seed the source with distance zero
                        reached_next[run_source] = 1'b1;
                        d_we       = 1'b1;
                        d_wr_addr  = run_source;
                        d_wr_data  = {run_source, DIST_W'(0)};
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one distance read a cycle
                if (cnt_reg < n_reg)
                begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = cnt_reg[VIDX_W-1:0];
                    cnt_next      = cnt_inc;
                end
                // compare returning distance against the running minimum
                if (pipe_vld_reg)
                begin
                    take = reached_reg[pipe_idx_reg] && !settled_reg[pipe_idx_reg] &&
                           (!found_reg || (rd_dist < best_reg));
                    if (take)
                    begin
                        found_next = 1'b1;
                        best_next  = rd_dist;
                        u_next     = pipe_idx_reg;
                    end
                end
                // end of scan: settle the minimum or finish
                if (pipe_last)
                begin
                    cnt_next      = '0;
                    pipe_vld_next = 1'b0;
                    if (found_next)
                    begin
                        settled_next[u_next] = 1'b1;
                        base_next  = WADDR_W'(u_next) * WADDR_W'(MAX_VERTICES);
                        state_next = S_RELAX;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end

            S_RELAX:
            begin
                // issue matrix cell and distance reads together
                if (cnt_reg < n_reg)
                begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = cnt_reg[VIDX_W-1:0];
                    cnt_next      = cnt_inc;
                end
                // a first reach or a strict improvement writes back distance and predecessor
                if (pipe_vld_reg && w_flag &&
                    (!reached_reg[pipe_idx_reg] || (cand < rd_dist)))
                begin
                    d_we = 1'b1;
                    reached_next[pipe_idx_reg] = 1'b1;
                end
                if (pipe_last)
                begin
                    cnt_next      = '0;
                    pipe_vld_next = 1'b0;
                    found_next    = 1'b0;
                    state_next    = S_SCAN;
                end
            end

            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end

            S_EMIT_LD:
            begin
                // read data holds while the output register is full
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.vertex = VERTEX_W'(cnt_reg[VIDX_W-1:0]);
                    out_data_next.last   = (cnt_reg == last_idx);
                    if (reached_reg[cnt_reg[VIDX_W-1:0]])
                    begin
                        out_data_next.distance    = DISTANCE_W'(rd_dist);
                        out_data_next.predecessor = VERTEX_W'(rd_pred);
                        out_data_next.reachable   = 1'b1;
                    end
                    else
                    begin
                        out_data_next.distance    = '0;
                        out_data_next.predecessor = '0;
                        out_data_next.reachable   = 1'b0;
                    end
                    if (cnt_reg == last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next  = cnt_inc;
                        d_rd_addr = cnt_inc[VIDX_W-1:0];
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            cnt_reg       <= '0;
            pipe_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            reached_reg   <= '0;
            settled_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            pipe_vld_reg  <= pipe_vld_next;
            found_reg     <= found_next;
            reached_reg   <= reached_next;
            settled_reg   <= settled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= pipe_idx_next;
        best_reg     <= best_next;
        u_reg        <= u_next;
        base_reg     <= base_next;
        out_data_reg <= out_data_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a settled vertex always has a distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (settled_reg & ~reached_reg) == '0)
        else $error("settled vertex without a distance");

    // at most one vertex settles per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $onehot0(settled_reg & ~$past(settled_reg)))
        else $error("more than one vertex settled at once");

    // distance memory is not written while results go out
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_RD || state_reg == S_EMIT_LD) |-> !d_we)
        else $error("distance write during result phase");

    // a result appears only from the result load step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_EMIT_LD)
        else $error("result raised outside the result phase");

    // no read is in flight while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pipe_vld_reg)
        else $error("read in flight while idle");

endmodule

@@ sv/shortest_path_dense_graph_unit.sv @@
`timescale 1ns / 1ps
// Load transaction: taken whenever the unit is idle, the next transaction can follow right after.
// Run transaction, n vertices in use, r of them reachable: busy for r+1 minimum scans and
// r row relaxations over the n vertices, then the results, each scan and relaxation reading
// the distance memory one vertex per cycle; a source outside the vertices in use goes straight to results.
// Results leave one per cycle unless stalled; input stalls until the last one loads.
// Reset clears the sequencer, sets vertex_count 32 and source_vertex 0; memories uncleared.
// ----------------------------------------------------------------------------
// shortest_path_dense_graph_unit
// Single source shortest paths over a dense adjacency matrix held in RAM,
// with a minimum scan and row relaxation per round.
// ----------------------------------------------------------------------------
module shortest_path_dense_graph_unit #(
    parameter int MAX_VERTICES = spd_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = spd_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_write,
    input  logic [spd_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0]         cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  spd_pkg::in_item_t                      in_data,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output spd_pkg::out_item_t                     out_data
);

    import spd_pkg::*;

    localparam int VIDX_W  = $clog2(MAX_VERTICES);
    localparam int NCNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int WADDR_W = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int DIST_W  = WEIGHT_BITS + VIDX_W;
    localparam int DENT_W  = VIDX_W + DIST_W;

    logic [VERTEX_COUNT_W-1:0]  vertex_count_reg;
    logic [SOURCE_VERTEX_W-1:0] source_vertex_reg;

    logic                 eng_idle;
    logic                 in_accept;
    logic                 load_in_range;
    logic                 w_we;
    logic [WADDR_W-1:0]   w_wr_addr;
    logic [WEIGHT_BITS:0] w_wr_data;
    logic [WADDR_W-1:0]   w_rd_addr;
    logic [WEIGHT_BITS:0] w_rd_data;
    logic                 d_we;
    logic [VIDX_W-1:0]    d_wr_addr;
    logic [DENT_W-1:0]    d_wr_data;
    logic [VIDX_W-1:0]    d_rd_addr;
    logic [DENT_W-1:0]    d_rd_data;
    logic [NCNT_W-1:0]    count_used;
    logic                 source_ok;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg  <= VERTEX_COUNT_RESET;
            source_vertex_reg <= SOURCE_VERTEX_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_VERTEX_COUNT)
            begin
                vertex_count_reg <= cfg_data[VERTEX_COUNT_W-1:0];
            end
            else if (cfg_index == REG_SOURCE_VERTEX)
            begin
                source_vertex_reg <= cfg_data[SOURCE_VERTEX_W-1:0];
            end
        end
    end

    // vertex count limited to one .. MAX_VERTICES
    always_comb
    begin
        priority if (vertex_count_reg == '0)
        begin
            count_used = NCNT_W'(1);
        end
        else if (int'(vertex_count_reg) > MAX_VERTICES)
        begin
            count_used = NCNT_W'(MAX_VERTICES);
        end
        else
        begin
            count_used = NCNT_W'(vertex_count_reg);
        end
    end

    assign source_ok = int'(source_vertex_reg) < int'(count_used);

    // input transaction handshake
    assign in_stall  = !eng_idle;
    assign in_accept = in_valid && !in_stall;

    // matrix cell load
    assign load_in_range = (int'(in_data.row) < MAX_VERTICES) &&
                           (int'(in_data.col) < MAX_VERTICES);
    assign w_we      = in_accept && (in_data.op == OP_LOAD) && load_in_range;
    assign w_wr_addr = WADDR_W'(in_data.row) * WADDR_W'(MAX_VERTICES) +
                       WADDR_W'(in_data.col);
    assign w_wr_data = {in_data.edge_present, WEIGHT_BITS'(in_data.cost)};

    spd_ram #(
        .WIDTH (WEIGHT_BITS + 1),
        .DEPTH (MAX_VERTICES * MAX_VERTICES)
    ) u_weight_ram (
        .clk     (clk),
        .we      (w_we),
        .wr_addr (w_wr_addr),
        .wr_data (w_wr_data),
        .rd_addr (w_rd_addr),
        .rd_data (w_rd_data)
    );

    // distance and predecessor per vertex
    spd_ram #(
        .WIDTH (DENT_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram (
        .clk     (clk),
        .we      (d_we),
        .wr_addr (d_wr_addr),
        .wr_data (d_wr_data),
        .rd_addr (d_rd_addr),
        .rd_data (d_rd_data)
    );

    spd_engine #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .run_start     (in_accept && (in_data.op == OP_RUN)),
        .run_count     (count_used),
        .run_source    (VIDX_W'(source_vertex_reg)),
        .run_source_ok (source_ok),
        .idle          (eng_idle),
        .w_rd_addr     (w_rd_addr),
        .w_rd_data     (w_rd_data),
        .d_we          (d_we),
        .d_wr_addr     (d_wr_addr),
        .d_wr_data     (d_wr_data),
        .d_rd_addr     (d_rd_addr),
        .d_rd_data     (d_rd_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data)
    );

endmodule
